/* src/apir_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helpers for the phase integration block.
// No dependencies; every other file depends on this package.
package apir_pkg;

	localparam int MAX_ROWS      = 2048;
	localparam int MAX_COLS      = 2048;
	localparam int PHASE_BITS    = 24;
	localparam int CORDIC_STAGES = 16;
	localparam int DIM_W         = 12;
	localparam int IDX_W         = 11;
	localparam int AMP_W         = 16;
	localparam int GRAD_W        = 16;
	localparam int SUM_W         = 19;
	localparam int OUT_W         = 17;
	localparam int ANG_W         = 32;
	localparam int XY_W          = 36;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;
	localparam int QUEUE_DEPTH   = 4;
	localparam int QPTR_W        = 2;
	localparam logic [29:0] CORDIC_K30 = 30'd652032874;

	typedef logic [PHASE_BITS-1:0] phase_t;

	// Register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NUM_ROWS  = 3'd0,
		REG_NUM_COLS  = 3'd1,
		REG_HORIZ_AS  = 3'd2,
		REG_VERT_AS   = 3'd3,
		REG_PH_R0C0   = 3'd4,
		REG_PH_R1C0   = 3'd5,
		REG_PH_R0C1   = 3'd6,
		REG_PH_R1C1   = 3'd7
	} cfg_reg_t;

	// Position of a pixel along one axis
	typedef enum logic [1:0] {
		POS_FIRST  = 2'd0,
		POS_SECOND = 2'd1,
		POS_REST   = 2'd2
	} pos_cls_t;

	typedef struct packed {
		logic   horiz_antisym;
		logic   vert_antisym;
		phase_t ph_r0c0;
		phase_t ph_r1c0;
		phase_t ph_r0c1;
		phase_t ph_r1c1;
	} cfg_t;

	typedef struct packed {
		logic [AMP_W-1:0]         amplitude;
		logic signed [GRAD_W-1:0] grad_u;
		logic signed [GRAD_W-1:0] grad_v;
		pos_cls_t                 col_cls;
		pos_cls_t                 row_cls;
		logic                     frame_end;
	} item_t;

	// Phase step for a gradient sum: 100 * s scaled by 2^(PHASE_BITS-14), modulo one turn
	function automatic phase_t step_of(input logic signed [SUM_W-1:0] s);
		logic signed [SUM_W+6:0] p;
		begin
			p = (SUM_W+7)'(s) * (SUM_W+7)'(100);
			step_of = {p[PHASE_BITS-11:0], 10'b0};
		end
	endfunction

	// CORDIC arctangent table, 2^-32 turns
	function automatic logic [ANG_W-1:0] atan_turns(input int i);
		begin
			case (i)
				0:  atan_turns = 32'h20000000;
				1:  atan_turns = 32'h12E4051E;
				2:  atan_turns = 32'h09FB385B;
				3:  atan_turns = 32'h051111D4;
				4:  atan_turns = 32'h028B0D43;
				5:  atan_turns = 32'h0145D7E1;
				6:  atan_turns = 32'h00A2F61E;
				7:  atan_turns = 32'h00517C55;
				8:  atan_turns = 32'h0028BE53;
				9:  atan_turns = 32'h00145F2F;
				10: atan_turns = 32'h000A2F98;
				11: atan_turns = 32'h000517CC;
				12: atan_turns = 32'h00028BE6;
				13: atan_turns = 32'h000145F3;
				14: atan_turns = 32'h0000A2FA;
				15: atan_turns = 32'h0000517D;
				16: atan_turns = 32'h000028BE;
				17: atan_turns = 32'h0000145F;
				18: atan_turns = 32'h00000A30;
				19: atan_turns = 32'h00000518;
				20: atan_turns = 32'h0000028C;
				21: atan_turns = 32'h00000146;
				22: atan_turns = 32'h000000A3;
				23: atan_turns = 32'h00000051;
				default: atan_turns = '0;
			endcase
		end
	endfunction

endpackage

/* src/apir_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for pixels in and results out.
// Depends on apir_pkg.
interface apir_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [apir_pkg::AMP_W-1:0]           amplitude;
	logic signed [apir_pkg::GRAD_W-1:0]   grad_u;
	logic signed [apir_pkg::GRAD_W-1:0]   grad_v;
	modport source (output valid, amplitude, grad_u, grad_v, input ready);
	modport sink   (input valid, amplitude, grad_u, grad_v, output ready);
endinterface

interface apir_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [apir_pkg::OUT_W-1:0]    real_part;
	logic signed [apir_pkg::OUT_W-1:0]    imag_part;
	logic [apir_pkg::PHASE_BITS-1:0]      phase;
	logic                                 frame_end;
	modport source (output valid, real_part, imag_part, phase, frame_end, input ready);
	modport sink   (input valid, real_part, imag_part, phase, frame_end, output ready);
endinterface

/* src/apir_front.sv */
`timescale 1ns / 1ps
// Front end: configuration registers, raster counters and pixel classification.
// Depends on apir_pkg and apir_in_if.
module apir_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apir_pkg::CFG_DATA_W-1:0] cfg_data,
	apir_in_if.sink                         pix_in,
	input  logic                            q_ready,
	output logic                            push,
	output apir_pkg::item_t                 push_item,
	output apir_pkg::cfg_t                  cfg
);
	import apir_pkg::*;

	logic [DIM_W-1:0] num_rows_q, num_cols_q, rows, cols;
	logic [IDX_W-1:0] row_q, col_q;
	logic             row_end, frame_end;
	cfg_t             cfg_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_W'(2);
			num_cols_q <= DIM_W'(2);
			cfg_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_NUM_ROWS: num_rows_q          <= cfg_data[DIM_W-1:0];
				REG_NUM_COLS: num_cols_q          <= cfg_data[DIM_W-1:0];
				REG_HORIZ_AS: cfg_q.horiz_antisym <= cfg_data[0];
				REG_VERT_AS:  cfg_q.vert_antisym  <= cfg_data[0];
				REG_PH_R0C0:  cfg_q.ph_r0c0       <= cfg_data[PHASE_BITS-1:0];
				REG_PH_R1C0:  cfg_q.ph_r1c0       <= cfg_data[PHASE_BITS-1:0];
				REG_PH_R0C1:  cfg_q.ph_r0c1       <= cfg_data[PHASE_BITS-1:0];
				REG_PH_R1C1:  cfg_q.ph_r1c1       <= cfg_data[PHASE_BITS-1:0];
				default: ;
			endcase
		end
	end
	assign cfg = cfg_q;

	// Clamp dimensions to [2, MAX]
	always_comb begin
		rows = (num_rows_q < DIM_W'(2)) ? DIM_W'(2) :
		       (num_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : num_rows_q;
		cols = (num_cols_q < DIM_W'(2)) ? DIM_W'(2) :
		       (num_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : num_cols_q;
	end

	assign pix_in.ready = q_ready;
	assign push         = pix_in.valid && q_ready;
	assign row_end      = ({1'b0, col_q} + DIM_W'(1)) >= cols;
	assign frame_end    = row_end && (({1'b0, row_q} + DIM_W'(1)) >= rows);

	// Classify the pixel position
	always_comb begin
		push_item.amplitude = pix_in.amplitude;
		push_item.grad_u    = pix_in.grad_u;
		push_item.grad_v    = pix_in.grad_v;
		push_item.col_cls   = (col_q == '0) ? POS_FIRST :
		                      (col_q == IDX_W'(1)) ? POS_SECOND : POS_REST;
		push_item.row_cls   = (row_q == '0) ? POS_FIRST :
		                      (row_q == IDX_W'(1)) ? POS_SECOND : POS_REST;
		push_item.frame_end = frame_end;
	end

	// Raster counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (push) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : row_q + IDX_W'(1);
			end else begin
				col_q <= col_q + IDX_W'(1);
			end
		end
	end
endmodule

/* src/apir_queue.sv */
`timescale 1ns / 1ps
// Short queue of classified pixels between front and back.
// Depends on apir_pkg.
module apir_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  apir_pkg::item_t push_item,
	output logic            q_ready,
	input  logic            pop,
	output logic            q_valid,
	output apir_pkg::item_t pop_item
);
	import apir_pkg::*;

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign q_ready  = cnt_q != (QPTR_W+1)'(QUEUE_DEPTH);
	assign q_valid  = cnt_q != '0;
	assign pop_item = mem_q[rd_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + QPTR_W'(1);
			if (pop)  rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end
endmodule

/* src/apir_back.sv */
`timescale 1ns / 1ps
// Back end: phase integration, quadrant/gain stage, CORDIC pipeline and output register.
// Depends on apir_pkg and apir_out_if.
module apir_back (
	input  logic            clk,
	input  logic            arst_n,
	input  apir_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  apir_pkg::item_t pop_item,
	output logic            pop,
	apir_out_if.source      pix_out
);
	import apir_pkg::*;

	localparam int NP = CORDIC_STAGES + 2;

	logic adv;
	logic vld_q [NP];

	// Integration history
	logic signed [GRAD_W-1:0] rg_q [2];
	phase_t                   rp_q [2];
	logic signed [GRAD_W-1:0] cg_q [4];
	phase_t                   cp_q [4];

	logic                     col1;
	logic signed [GRAD_W-1:0] gh0, gh1;
	phase_t                   cph1, colph, ph;
	logic signed [SUM_W-1:0]  su1, su2, sv1, sv2;

	assign adv = !pix_out.valid || pix_out.ready;
	assign pop = q_valid && adv;

	// Column and row recurrences
	always_comb begin
		col1 = pop_item.col_cls == POS_SECOND;
		gh0  = col1 ? cg_q[2] : cg_q[0];
		gh1  = col1 ? cg_q[3] : cg_q[1];
		cph1 = col1 ? cp_q[3] : cp_q[1];
		su1  = SUM_W'(pop_item.grad_u) + (SUM_W'(gh0) <<< 1);
		su2  = SUM_W'(pop_item.grad_u) + (SUM_W'(gh0) <<< 2) + SUM_W'(gh1);
		sv1  = SUM_W'(pop_item.grad_v) + (SUM_W'(rg_q[0]) <<< 1);
		sv2  = SUM_W'(pop_item.grad_v) + (SUM_W'(rg_q[0]) <<< 2) + SUM_W'(rg_q[1]);
		case (pop_item.row_cls)
			POS_FIRST:  colph = cfg.vert_antisym ? '0 : (col1 ? cfg.ph_r0c1 : cfg.ph_r0c0);
			POS_SECOND: colph = cfg.vert_antisym ? step_of(su1)
			                                     : (col1 ? cfg.ph_r1c1 : cfg.ph_r1c0);
			default:    colph = cph1 + step_of(su2);
		endcase
		case (pop_item.col_cls)
			POS_FIRST:  ph = cfg.horiz_antisym ? '0 : colph;
			POS_SECOND: ph = cfg.horiz_antisym ? step_of(sv1) : colph;
			default:    ph = rp_q[1] + step_of(sv2);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rg_q <= '{default: '0};
			rp_q <= '{default: '0};
			cg_q <= '{default: '0};
			cp_q <= '{default: '0};
		end else if (pop) begin
			rg_q[1] <= rg_q[0];
			rg_q[0] <= pop_item.grad_v;
			rp_q[1] <= rp_q[0];
			rp_q[0] <= ph;
			if (pop_item.col_cls != POS_REST) begin
				cg_q[{col1, 1'b1}] <= gh0;
				cg_q[{col1, 1'b0}] <= pop_item.grad_u;
				cp_q[{col1, 1'b1}] <= cp_q[{col1, 1'b0}];
				cp_q[{col1, 1'b0}] <= colph;
			end
		end
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '{default: 1'b0};
		end else if (adv) begin
			vld_q[0] <= pop;
			for (int k = 1; k < NP; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	// Phase and frame mark ride along the pipeline
	phase_t           ph_p  [NP];
	logic             fe_p  [NP];
	logic [AMP_W-1:0] amp_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ph_p[0] <= ph;
			fe_p[0] <= pop_item.frame_end;
			amp_s1  <= pop_item.amplitude;
			for (int k = 1; k < NP; k++) begin
				ph_p[k] <= ph_p[k-1];
				fe_p[k] <= fe_p[k-1];
			end
		end
	end

	// Quadrant reduction and scaled amplitude
	logic [ANG_W-1:0]        ang, rem;
	logic [1:0]              quad, quad_s2;
	logic signed [ANG_W-1:0] z_s2;
	logic [45:0]             prod;
	logic [ANG_W-1:0]        m_s2;

	always_comb begin
		ang  = {ph_p[0], (ANG_W-PHASE_BITS)'(0)};
		quad = 2'((ang + 32'h20000000) >> 30);
		rem  = ang - {quad, 30'b0};
		prod = 46'(amp_s1) * 46'(CORDIC_K30);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			quad_s2 <= quad;
			z_s2    <= rem;
			m_s2    <= prod[45:14];
		end
	end

	// CORDIC rotation, one stage per register
	logic signed [XY_W-1:0]  cx [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]  cy [CORDIC_STAGES+1];
	logic signed [ANG_W-1:0] cz [CORDIC_STAGES+1];
	logic signed [XY_W-1:0]  m_ext;

	always_comb begin
		m_ext = XY_W'(m_s2);
		cz[0] = z_s2;
		case (quad_s2)
			2'd0:    begin cx[0] = m_ext;  cy[0] = '0;     end
			2'd1:    begin cx[0] = '0;     cy[0] = m_ext;  end
			2'd2:    begin cx[0] = -m_ext; cy[0] = '0;     end
			default: begin cx[0] = '0;     cy[0] = -m_ext; end
		endcase
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!cz[i][ANG_W-1]) begin
					cx[i+1] <= cx[i] - (cy[i] >>> i);
					cy[i+1] <= cy[i] + (cx[i] >>> i);
					cz[i+1] <= cz[i] - $signed(atan_turns(i));
				end else begin
					cx[i+1] <= cx[i] + (cy[i] >>> i);
					cy[i+1] <= cy[i] - (cx[i] >>> i);
					cz[i+1] <= cz[i] + $signed(atan_turns(i));
				end
			end
		end
	end

	// Round half up and saturate
	function automatic logic signed [OUT_W-1:0] finish(input logic signed [XY_W-1:0] v);
		logic signed [XY_W-1:0] r;
		begin
			r = (v + XY_W'(32768)) >>> 16;
			if (r > XY_W'(65535))       finish = OUT_W'(65535);
			else if (r < -XY_W'(65536)) finish = OUT_W'(-65536);
			else                        finish = r[OUT_W-1:0];
		end
	endfunction

	// Output register
	logic out_valid_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (adv) out_valid_q <= vld_q[NP-1];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pix_out.real_part <= finish(cx[CORDIC_STAGES]);
			pix_out.imag_part <= finish(cy[CORDIC_STAGES]);
			pix_out.phase     <= ph_p[NP-1];
			pix_out.frame_end <= fe_p[NP-1];
		end
	end
	assign pix_out.valid = out_valid_q;
endmodule

/* src/amfm_phase_integrate_reconstruct.sv */
`timescale 1ns / 1ps
// Top level: phase-gradient integration and amplitude/phase pixel reconstruction.
// Depends on apir_pkg, apir_if, apir_front, apir_queue and apir_back.
//
//  channel   dir  handshake        payload
//  pix_in    in   valid/ready      amplitude, grad_u, grad_v
//  pix_out   out  valid/ready      real_part, imag_part, phase, frame_end
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// One pixel per cycle sustained while pix_out is ready; from the queue a pixel passes integration,
// the gain multiply, 16 CORDIC stages and the output register.
// Reset clears counters, history and phase config (dimensions return to 2); no clearing pass.
// Output stall freezes the back pipeline; the 4-entry queue lets the front keep taking until it is full.
module amfm_phase_integrate_reconstruct (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apir_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [apir_pkg::CFG_DATA_W-1:0] cfg_data,
	apir_in_if.sink                         pix_in,
	apir_out_if.source                      pix_out
);
	import apir_pkg::*;

	logic  push, pop, q_ready, q_valid;
	item_t push_item, pop_item;
	cfg_t  cfg;

	apir_front u_front (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.pix_in, .q_ready, .push, .push_item, .cfg
	);

	apir_queue u_queue (
		.clk, .arst_n, .push, .push_item, .q_ready, .pop, .q_valid, .pop_item
	);

	apir_back u_back (
		.clk, .arst_n, .cfg, .q_valid, .pop_item, .pop, .pix_out
	);

`ifndef NO_ASSERTIONS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_valid) else $error("pop from empty queue");
	a_stall_no_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready) |-> !pop) else $error("pop during output stall");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop && !q_ready) |-> 1'b0) else $error("push into full queue");
`endif
endmodule
